>>> rtl/fpt_pkg.sv
// ---------------------------------------------------------------------------
// fpt_pkg: shared types and constants for the frame point transform
// Widths of the coordinate, product, sum and divider paths, register
// indexes and the per-stage request record.
// ---------------------------------------------------------------------------
package fpt_pkg;

    // coordinate format
    localparam int CW   = 16;           // component width
    localparam int FB   = 8;            // fraction bits
    localparam int VW   = 3 * CW;       // packed vector width
    localparam int IDXW = 2;            // register index width

    // datapath widths
    localparam int DW   = CW + 1;               // point minus origin
    localparam int PW   = DW + CW;              // one product
    localparam int SW   = PW + 2;               // sum of three products
    localparam int DENW = 2 * CW;               // squared axis length
    localparam int D2W  = DENW + 1;             // doubled divisor
    localparam int RW   = SW + FB + 2;          // dividend / remainder
    localparam int QB   = CW + 1;               // quotient bits
    localparam int DSW  = D2W + QB - 1;         // shifted divisor
    localparam int XW   = ((RW > DSW) ? RW : DSW) + 1;  // compare width
    localparam int HALF = (FB > 0) ? (1 << (FB - 1)) : 0;

    // register indexes
    localparam logic [IDXW-1:0] REG_AXIS_X = 2'd0;
    localparam logic [IDXW-1:0] REG_AXIS_Y = 2'd1;
    localparam logic [IDXW-1:0] REG_AXIS_Z = 2'd2;
    localparam logic [IDXW-1:0] REG_ORIGIN = 2'd3;

    // direction codes
    localparam logic CMD_TO_WORLD = 1'b0;
    localparam logic CMD_TO_LOCAL = 1'b1;

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam coord_t MINV = {1'b1, {(CW-1){1'b0}}};

    // one divider lane
    typedef struct packed {
        logic            zero;
        logic            neg;
        logic            ovf;
        logic [QB-1:0]   quo;
        logic [RW-1:0]   rem;
        logic [DSW-1:0]  dsh;
    } lane_t;

    // request record carried down the pipeline
    typedef struct packed {
        logic             cmd;
        lane_t [2:0]      lane;
        coord_t [2:0]     fq;
        logic             fsat;
    } stage_t;

    // component i of a packed vector
    function automatic coord_t comp(input logic [VW-1:0] v, input int i);
        comp = v[i*CW +: CW];
    endfunction

endpackage

>>> rtl/frame_point_transform.sv
// ---------------------------------------------------------------------------
// frame_point_transform: 3D point transform between a local frame and world
//
// Requests enter on req_valid / req_stall with cmd, px, py, pz; results
// leave on rsp_valid / rsp_stall with qx, qy, qz, saturated and
// degenerate_axis, one result per request, in order.
// The frame (three axes and an origin) is written through cfg_valid /
// cfg_ready / cfg_index / cfg_data; cfg_ready is always high. Write it only
// while no request is in flight.
// The pipeline has 4 front stages (offset, products, sums, rounding),
// 1 divider setup stage, 17 divide steps (one quotient bit each) and the
// output register. Throughput is one request per cycle while no result is
// held by rsp_stall; the divide chain sets the depth.
// After reset the pipeline is empty and the frame is the identity.
// While a result is held by rsp_stall the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module frame_point_transform
    import fpt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    // request channel
    input  logic            req_valid,
    output logic            req_stall,
    input  logic            cmd,
    input  coord_t          px,
    input  coord_t          py,
    input  coord_t          pz,
    // result channel
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output coord_t          qx,
    output coord_t          qy,
    output coord_t          qz,
    output logic            saturated,
    output logic            degenerate_axis,
    // configuration channel
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [IDXW-1:0] cfg_index,
    input  logic [VW-1:0]   cfg_data
);

    localparam logic [QB-1:0] QMAX = QB'(2**(CW-1) - 1);
    localparam logic [QB-1:0] QNEG = QB'(2**(CW-1));

    logic [VW-1:0] axis_x_reg;
    logic [VW-1:0] axis_y_reg;
    logic [VW-1:0] axis_z_reg;
    logic [VW-1:0] origin_reg;

    logic          en;
    logic          front_vld;
    stage_t        front_stg;
    logic          e_vld_reg;
    stage_t        e_reg;
    stage_t        e_next;
    logic          chain_vld [QB+1];
    stage_t        chain_stg [QB+1];

    logic          out_vld_reg;
    logic          out_cmd_reg;
    coord_t        q_reg [3];
    logic          sat_reg;
    logic          degen_reg;
    coord_t        q_next [3];
    logic [2:0]    sat_v;
    logic [2:0]    degen_v;
    logic [QB-1:0] negq [3];
    stage_t        fin;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg <= VW'(1) << FB;
            axis_y_reg <= VW'(1) << (FB + CW);
            axis_z_reg <= VW'(1) << (FB + 2 * CW);
            origin_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AXIS_X: axis_x_reg <= cfg_data;
                REG_AXIS_Y: axis_y_reg <= cfg_data;
                REG_AXIS_Z: axis_z_reg <= cfg_data;
                REG_ORIGIN: origin_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // global advance: hold everything while a result is refused
    assign en        = !(out_vld_reg && rsp_stall);
    assign req_stall = !en;

    fpt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_i  (req_valid),
        .cmd    (cmd),
        .px     (px),
        .py     (py),
        .pz     (pz),
        .axis_x (axis_x_reg),
        .axis_y (axis_y_reg),
        .axis_z (axis_z_reg),
        .origin (origin_reg),
        .vld_o  (front_vld),
        .stg_o  (front_stg)
    );

    // divider setup: range check and divisor alignment
    always_comb
    begin
        e_next = front_stg;
        for (int i = 0; i < 3; i++)
        begin
            e_next.lane[i].ovf = XW'(front_stg.lane[i].rem)
                              >= (XW'(front_stg.lane[i].dsh) << QB);
            e_next.lane[i].dsh = front_stg.lane[i].dsh << (QB - 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= front_vld;
        end
    end

    // divide chain, most significant quotient bit first
    assign chain_vld[0] = e_vld_reg;
    assign chain_stg[0] = e_reg;

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        fpt_div_stage u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vld_i (chain_vld[j]),
            .stg_i (chain_stg[j]),
            .vld_o (chain_vld[j+1]),
            .stg_o (chain_stg[j+1])
        );
    end

    // final select, sign and clamp
    assign fin = chain_stg[QB];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            negq[i]    = QB'(0) - fin.lane[i].quo;
            sat_v[i]   = 1'b0;
            degen_v[i] = 1'b0;
            if (fin.cmd == CMD_TO_WORLD)
            begin
                q_next[i] = fin.fq[i];
            end
            else if (fin.lane[i].zero)
            begin
                q_next[i]  = '0;
                degen_v[i] = 1'b1;
            end
            else if (fin.lane[i].neg)
            begin
                if (fin.lane[i].ovf || (fin.lane[i].quo > QNEG))
                begin
                    q_next[i] = MINV;
                    sat_v[i]  = 1'b1;
                end
                else
                begin
                    q_next[i] = negq[i][CW-1:0];
                end
            end
            else
            begin
                if (fin.lane[i].ovf || (fin.lane[i].quo > QMAX))
                begin
                    q_next[i] = MAXV;
                    sat_v[i]  = 1'b1;
                end
                else
                begin
                    q_next[i] = fin.lane[i].quo[CW-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_cmd_reg <= fin.cmd;
            for (int i = 0; i < 3; i++)
            begin
                q_reg[i] <= q_next[i];
            end
            sat_reg   <= (fin.cmd == CMD_TO_WORLD) ? fin.fsat : |sat_v;
            degen_reg <= |degen_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= chain_vld[QB];
        end
    end

    assign rsp_valid       = out_vld_reg;
    assign qx              = q_reg[0];
    assign qy              = q_reg[1];
    assign qz              = q_reg[2];
    assign saturated       = sat_reg;
    assign degenerate_axis = degen_reg;

    // checks
    a_degen_local: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && degenerate_axis |-> out_cmd_reg == CMD_TO_LOCAL)
        else $error("degenerate flag on a local to world result");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && degenerate_axis |-> (qx == '0) || (qy == '0) || (qz == '0))
        else $error("degenerate flag with no zeroed component");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && saturated |->
            (qx == MAXV) || (qx == MINV) || (qy == MAXV) || (qy == MINV)
            || (qz == MAXV) || (qz == MINV))
        else $error("saturated flag with no component at a rail");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (rsp_valid && rsp_stall))
        else $error("request stall does not follow the held result");

endmodule

>>> rtl/fpt_front.sv
// ---------------------------------------------------------------------------
// fpt_front: front end of the transform pipeline
// Offset, nine products, sums, then the forward result and divider setup,
// four register stages.
// ---------------------------------------------------------------------------
module fpt_front
    import fpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_i,
    input  logic          cmd,
    input  coord_t        px,
    input  coord_t        py,
    input  coord_t        pz,
    input  logic [VW-1:0] axis_x,
    input  logic [VW-1:0] axis_y,
    input  logic [VW-1:0] axis_z,
    input  logic [VW-1:0] origin,
    output logic          vld_o,
    output stage_t        stg_o
);

    localparam logic signed [SW+1:0] RMAX = (SW+2)'(MAXV);
    localparam logic signed [SW+1:0] RMIN = (SW+2)'(MINV);

    // stage A: point and offset from origin
    logic                 a_vld_reg;
    logic                 a_cmd_reg;
    coord_t               a_p_reg  [3];
    logic signed [DW-1:0] a_d_reg  [3];
    coord_t               p_in     [3];
    logic signed [DW-1:0] d_next   [3];

    // stage B: products
    logic                 b_vld_reg;
    logic                 b_cmd_reg;
    logic signed [PW-1:0] b_prod_reg [3][3];
    logic [DENW-1:0]      b_sq_reg   [3][3];
    logic [VW-1:0]        axv        [3];
    logic signed [DW-1:0] lhs        [3][3];
    coord_t               rhs        [3][3];
    coord_t               acomp      [3][3];
    logic signed [PW-1:0] prod_next  [3][3];
    logic signed [DENW-1:0] sq_next  [3][3];

    // stage C: sums
    logic                 c_vld_reg;
    logic                 c_cmd_reg;
    logic signed [SW-1:0] c_s_reg    [3];
    logic [DENW-1:0]      c_den_reg  [3];
    logic signed [SW-1:0] s_next     [3];
    logic [DENW-1:0]      den_next   [3];

    // stage D: forward result and divider setup
    logic                 d_vld_reg;
    stage_t               d_reg;
    stage_t               d_next_stg;
    logic signed [SW+1:0] rt0 [3];
    logic signed [SW+1:0] rt1 [3];
    logic signed [SW+1:0] rt2 [3];
    logic [SW-1:0]        mag [3];
    logic [2:0]           fsat_v;

    // stage A
    always_comb
    begin
        p_in[0] = px;
        p_in[1] = py;
        p_in[2] = pz;
        for (int k = 0; k < 3; k++)
        begin
            d_next[k] = DW'(p_in[k]) - DW'(comp(origin, k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_cmd_reg <= cmd;
            for (int k = 0; k < 3; k++)
            begin
                a_p_reg[k] <= p_in[k];
                a_d_reg[k] <= d_next[k];
            end
        end
    end

    // stage B: row i, column k
    always_comb
    begin
        axv[0] = axis_x;
        axv[1] = axis_y;
        axv[2] = axis_z;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                acomp[i][k] = comp(axv[i], k);
                lhs[i][k]   = (a_cmd_reg == CMD_TO_LOCAL) ? a_d_reg[k] : DW'(a_p_reg[k]);
                rhs[i][k]   = (a_cmd_reg == CMD_TO_LOCAL) ? comp(axv[i], k)
                                                          : comp(axv[k], i);
                prod_next[i][k] = lhs[i][k] * rhs[i][k];
                sq_next[i][k]   = acomp[i][k] * acomp[i][k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_cmd_reg <= a_cmd_reg;
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    b_prod_reg[i][k] <= prod_next[i][k];
                    b_sq_reg[i][k]   <= DENW'(unsigned'(sq_next[i][k]));
                end
            end
        end
    end

    // stage C
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_next[i] = SW'(b_prod_reg[i][0]) + SW'(b_prod_reg[i][1])
                      + SW'(b_prod_reg[i][2]);
            den_next[i] = b_sq_reg[i][0] + b_sq_reg[i][1] + b_sq_reg[i][2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_cmd_reg <= b_cmd_reg;
            for (int i = 0; i < 3; i++)
            begin
                c_s_reg[i]   <= s_next[i];
                c_den_reg[i] <= den_next[i];
            end
        end
    end

    // stage D: round, add origin, clamp; dividend and divisor
    always_comb
    begin
        d_next_stg.cmd = c_cmd_reg;
        for (int i = 0; i < 3; i++)
        begin
            rt0[i] = (SW+2)'(c_s_reg[i]) + (SW+2)'(HALF);
            rt1[i] = rt0[i] >>> FB;
            rt2[i] = rt1[i] + (SW+2)'(comp(origin, i));
            if (rt2[i] > RMAX)
            begin
                d_next_stg.fq[i] = MAXV;
                fsat_v[i] = 1'b1;
            end
            else if (rt2[i] < RMIN)
            begin
                d_next_stg.fq[i] = MINV;
                fsat_v[i] = 1'b1;
            end
            else
            begin
                d_next_stg.fq[i] = CW'(rt2[i]);
                fsat_v[i] = 1'b0;
            end

            mag[i] = c_s_reg[i][SW-1] ? SW'(-c_s_reg[i]) : SW'(c_s_reg[i]);
            d_next_stg.lane[i].zero = (c_den_reg[i] == '0);
            d_next_stg.lane[i].neg  = c_s_reg[i][SW-1];
            d_next_stg.lane[i].ovf  = 1'b0;
            d_next_stg.lane[i].quo  = '0;
            d_next_stg.lane[i].rem  = (RW'(mag[i]) << (FB + 1)) + RW'(c_den_reg[i]);
            d_next_stg.lane[i].dsh  = DSW'({c_den_reg[i], 1'b0});
        end
        d_next_stg.fsat = |fsat_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next_stg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= vld_i;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    assign vld_o = d_vld_reg;
    assign stg_o = d_reg;

endmodule

>>> rtl/fpt_div_stage.sv
// ---------------------------------------------------------------------------
// fpt_div_stage: one restoring divide step on all three lanes
// Compares the remainder with the aligned divisor, subtracts, shifts one
// quotient bit in and moves the divisor down a place.
// ---------------------------------------------------------------------------
module fpt_div_stage
    import fpt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   vld_i,
    input  stage_t stg_i,
    output logic   vld_o,
    output stage_t stg_o
);

    logic          vld_reg;
    stage_t        stg_reg;
    stage_t        stg_next;
    logic [XW-1:0] r_ext [3];
    logic [XW-1:0] s_ext [3];
    logic [XW-1:0] diff  [3];
    logic [2:0]    ge;

    // one step per lane
    always_comb
    begin
        stg_next = stg_i;
        for (int i = 0; i < 3; i++)
        begin
            r_ext[i] = XW'(stg_i.lane[i].rem);
            s_ext[i] = XW'(stg_i.lane[i].dsh);
            diff[i]  = r_ext[i] - s_ext[i];
            ge[i]    = (r_ext[i] >= s_ext[i]);
            stg_next.lane[i].rem = ge[i] ? RW'(diff[i]) : stg_i.lane[i].rem;
            stg_next.lane[i].quo = {stg_i.lane[i].quo[QB-2:0], ge[i]};
            stg_next.lane[i].dsh = stg_i.lane[i].dsh >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg <= stg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_i;
        end
    end

    assign vld_o = vld_reg;
    assign stg_o = stg_reg;

endmodule
